### rtl/plc_pkg.sv
// Shared types, constants and codes of the partition layout calculator.
package plc_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int FW          = 48;
    localparam int BSW         = 17;
    localparam int IDXW        = 9;
    localparam int DIV_CNTW    = $clog2(FW);
    localparam int QDEPTH      = 2;
    localparam int QPW         = $clog2(QDEPTH);
    localparam int QCW         = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CONFIG  = 3'd1,
        ST_START   = 3'd2,
        ST_OVERLAP = 3'd3,
        ST_EXCEEDS = 3'd4,
        ST_ABORTED = 3'd5,
        ST_IGNORED = 3'd6
    } status_t;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ALIGN    = 2'd0;
    localparam reg_idx_t REG_RESERVED = 2'd1;
    localparam reg_idx_t REG_BSIZE    = 2'd2;
    localparam reg_idx_t REG_TOTAL    = 2'd3;

    typedef struct packed {
        logic [FW-1:0]  align_bytes;
        logic [FW-1:0]  reserved_bytes;
        logic [BSW-1:0] block_size;
        logic [FW-1:0]  total_blocks;
    } cfg_t;

    typedef struct packed {
        logic [FW-1:0]   start_bytes;
        logic [FW-1:0]   size_bytes;
        logic            last_entry;
        logic [IDXW-1:0] entry_idx;
        logic            ignored;
        logic            extend;
    } item_t;

    typedef struct packed {
        logic          start;
        logic [FW-1:0] dividend;
        logic [FW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [FW-1:0] quotient;
        logic [FW-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CFG_A,
        B_CFG_R,
        B_START_A,
        B_START_S,
        B_SIZE,
        B_CHECK,
        B_LIMIT,
        B_EXT_DIV,
        B_END_SUM,
        B_END_DIV,
        B_ROUND,
        B_FIN
    } back_state_t;

endpackage

### rtl/plc_front.sv
// Intake stage: accepts entries, numbers them and tags ignored and extendable ones.
module plc_front import plc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [FW-1:0]   start_bytes,
    input  logic [FW-1:0]   size_bytes,
    input  logic            last_entry,
    input  logic            q_full,
    output logic            q_push,
    output item_t           q_item
);

    logic [IDXW-1:0] idx_reg;
    logic [IDXW-1:0] idx_next;
    logic            accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    always_comb
    begin
        q_item.start_bytes = start_bytes;
        q_item.size_bytes  = size_bytes;
        q_item.last_entry  = last_entry;
        q_item.entry_idx   = idx_reg;
        q_item.ignored     = (idx_reg >= IDXW'(MAX_ENTRIES));
        q_item.extend      = last_entry || (idx_reg == IDXW'(MAX_ENTRIES - 1));
    end

    // The count stops at the entry limit and restarts after the last entry.
    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (last_entry)
            begin
                idx_next = '0;
            end
            else if (idx_reg < IDXW'(MAX_ENTRIES))
            begin
                idx_next = idx_reg + IDXW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

### rtl/plc_fifo.sv
// Short queue of classified entries between the intake and the layout sequencer.
module plc_fifo import plc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head_item,
    output logic  empty
);

    item_t            mem_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   cnt_reg;
    logic [QCW-1:0]   cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == QCW'(QDEPTH));
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/plc_div.sv
// Shared restoring divider, one quotient bit per cycle.
module plc_div import plc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [DIV_CNTW-1:0] cnt_reg;
    logic [FW-1:0]       quo_reg;
    logic [FW-1:0]       rem_reg;
    logic [FW-1:0]       dsr_reg;
    logic [FW:0]         shifted;
    logic [FW+1:0]       diff;
    logic                qbit;
    logic [FW-1:0]       rem_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[FW-1]};
        diff     = {1'b0, shifted} - {2'b00, dsr_reg};
        qbit     = !diff[FW+1];
        rem_next = qbit ? diff[FW-1:0] : shifted[FW-1:0];
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNTW'(FW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNTW'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[FW-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

endmodule

### rtl/plc_back.sv
// Layout sequencer: runs the checks and block arithmetic of one entry and holds the result.
module plc_back import plc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            q_empty,
    output logic            q_pop,
    input  item_t           q_item,
    output div_req_t        div_req,
    input  div_rsp_t        div_rsp,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [IDXW-1:0] entry_number,
    output logic [FW-1:0]   start_block,
    output logic [FW-1:0]   size_block,
    output logic [2:0]      status,
    output logic            table_done
);

    back_state_t     state_reg;
    back_state_t     state_next;
    logic            issued_reg;
    logic            issued_next;
    logic            error_seen_reg;
    logic            error_seen_next;
    logic [FW-1:0]   next_offset_reg;
    logic [FW-1:0]   next_offset_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    item_t           item_reg;
    item_t           item_next;
    status_t         status_reg;
    status_t         status_next;
    logic [FW-1:0]   align_step_reg;
    logic [FW-1:0]   align_step_next;
    logic [FW-1:0]   res_blk_reg;
    logic [FW-1:0]   res_blk_next;
    logic [FW-1:0]   s_blk_reg;
    logic [FW-1:0]   s_blk_next;
    logic [FW-1:0]   z_blk_reg;
    logic [FW-1:0]   z_blk_next;
    logic [FW-1:0]   avail_reg;
    logic [FW-1:0]   avail_next;
    logic [FW-1:0]   end_reg;
    logic [FW-1:0]   end_next;
    logic [FW-1:0]   pad_reg;
    logic [FW-1:0]   pad_next;

    logic [IDXW-1:0] entry_number_reg;
    logic [FW-1:0]   start_block_reg;
    logic [FW-1:0]   size_block_reg;
    status_t         status_out_reg;
    logic            table_done_reg;

    logic            is_div;
    logic            div_fin;
    logic            out_free;
    logic            rem_zero;
    logic [FW:0]     limit_diff;
    logic            exceeds;
    logic [FW:0]     round_sum;
    logic            is_error;

    assign div_fin  = issued_reg && div_rsp.done;
    assign out_free = !out_valid_reg || out_ready;
    assign rem_zero = (div_rsp.remainder == '0);

    // Room left after start and size must still hold the reserved tail.
    assign limit_diff = {1'b0, avail_reg} - {1'b0, z_blk_reg};
    assign exceeds    = limit_diff[FW] || (res_blk_reg > limit_diff[FW-1:0]);
    assign round_sum  = {1'b0, end_reg} + {1'b0, pad_reg};
    assign is_error   = (status_reg == ST_CONFIG) || (status_reg == ST_START) ||
                        (status_reg == ST_OVERLAP) || (status_reg == ST_EXCEEDS);

    always_comb
    begin
        case (state_reg)
            B_CFG_A, B_CFG_R, B_START_A, B_START_S, B_SIZE, B_EXT_DIV, B_END_DIV:
                is_div = 1'b1;
            default:
                is_div = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_empty)
                begin
                    if (q_item.ignored || error_seen_reg || (cfg.block_size == '0))
                    begin
                        state_next = B_FIN;
                    end
                    else
                    begin
                        state_next = B_CFG_A;
                    end
                end
            B_CFG_A:
                if (div_fin)
                begin
                    state_next = rem_zero ? B_CFG_R : B_FIN;
                end
            B_CFG_R:
                if (div_fin)
                begin
                    if (!rem_zero)
                    begin
                        state_next = B_FIN;
                    end
                    else if (cfg.align_bytes != '0)
                    begin
                        state_next = B_START_A;
                    end
                    else
                    begin
                        state_next = B_START_S;
                    end
                end
            B_START_A:
                if (div_fin)
                begin
                    state_next = rem_zero ? B_START_S : B_FIN;
                end
            B_START_S:
                if (div_fin)
                begin
                    state_next = B_SIZE;
                end
            B_SIZE:
                if (div_fin)
                begin
                    state_next = B_CHECK;
                end
            B_CHECK:
                if ((s_blk_reg < next_offset_reg) || (s_blk_reg > cfg.total_blocks))
                begin
                    state_next = B_FIN;
                end
                else
                begin
                    state_next = B_LIMIT;
                end
            B_LIMIT:
                if (exceeds)
                begin
                    state_next = B_FIN;
                end
                else if (item_reg.extend && (z_blk_reg == '0))
                begin
                    state_next = B_EXT_DIV;
                end
                else
                begin
                    state_next = B_END_SUM;
                end
            B_EXT_DIV:
                if (div_fin)
                begin
                    state_next = B_END_SUM;
                end
            B_END_SUM:
                state_next = B_END_DIV;
            B_END_DIV:
                if (div_fin)
                begin
                    state_next = B_ROUND;
                end
            B_ROUND:
                state_next = B_FIN;
            B_FIN:
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            default:
                state_next = B_IDLE;
        endcase
    end

    // Divider requests and queue pop.
    always_comb
    begin
        q_pop            = (state_reg == B_IDLE) && !q_empty;
        div_req.start    = is_div && !issued_reg;
        div_req.dividend = item_reg.start_bytes;
        div_req.divisor  = FW'(cfg.block_size);
        case (state_reg)
            B_CFG_A:
                div_req.dividend = cfg.align_bytes;
            B_CFG_R:
                div_req.dividend = cfg.reserved_bytes;
            B_START_A:
                div_req.divisor = cfg.align_bytes;
            B_SIZE:
                div_req.dividend = item_reg.size_bytes;
            B_EXT_DIV:
            begin
                div_req.dividend = z_blk_reg;
                div_req.divisor  = align_step_reg;
            end
            B_END_DIV:
            begin
                div_req.dividend = end_reg;
                div_req.divisor  = align_step_reg;
            end
            default:
                div_req.divisor = FW'(cfg.block_size);
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        issued_next      = issued_reg;
        error_seen_next  = error_seen_reg;
        next_offset_next = next_offset_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        item_next        = item_reg;
        status_next      = status_reg;
        align_step_next  = align_step_reg;
        res_blk_next     = res_blk_reg;
        s_blk_next       = s_blk_reg;
        z_blk_next       = z_blk_reg;
        avail_next       = avail_reg;
        end_next         = end_reg;
        pad_next         = pad_reg;

        if (div_req.start)
        begin
            issued_next = 1'b1;
        end
        else if (div_fin)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
                if (!q_empty)
                begin
                    item_next = q_item;
                    if (q_item.ignored)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else if (error_seen_reg)
                    begin
                        status_next = ST_ABORTED;
                    end
                    else if (cfg.block_size == '0)
                    begin
                        status_next = ST_CONFIG;
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                end
            B_CFG_A:
                if (div_fin)
                begin
                    if (!rem_zero)
                    begin
                        status_next = ST_CONFIG;
                    end
                    align_step_next = (cfg.align_bytes == '0) ? FW'(1) : div_rsp.quotient;
                end
            B_CFG_R:
                if (div_fin)
                begin
                    if (!rem_zero)
                    begin
                        status_next = ST_CONFIG;
                    end
                    res_blk_next = div_rsp.quotient;
                end
            B_START_A:
                if (div_fin && !rem_zero)
                begin
                    status_next = ST_START;
                end
            B_START_S:
                if (div_fin)
                begin
                    // A start of zero blocks follows the previous partition.
                    s_blk_next = (div_rsp.quotient == '0) ? next_offset_reg : div_rsp.quotient;
                end
            B_SIZE:
                if (div_fin)
                begin
                    z_blk_next = div_rsp.quotient;
                end
            B_CHECK:
            begin
                avail_next = cfg.total_blocks - s_blk_reg;
                if (s_blk_reg < next_offset_reg)
                begin
                    status_next = ST_OVERLAP;
                end
                else if (s_blk_reg > cfg.total_blocks)
                begin
                    status_next = ST_EXCEEDS;
                end
            end
            B_LIMIT:
                if (exceeds)
                begin
                    status_next = ST_EXCEEDS;
                end
                else if (item_reg.extend && (z_blk_reg == '0))
                begin
                    z_blk_next = avail_reg - res_blk_reg;
                end
            B_EXT_DIV:
                if (div_fin)
                begin
                    z_blk_next = z_blk_reg - div_rsp.remainder;
                end
            B_END_SUM:
                end_next = s_blk_reg + z_blk_reg;
            B_END_DIV:
                if (div_fin)
                begin
                    pad_next = rem_zero ? '0 : align_step_reg - div_rsp.remainder;
                end
            B_ROUND:
                // The rounded end saturates at the top of the address range.
                next_offset_next = round_sum[FW] ? {FW{1'b1}} : round_sum[FW-1:0];
            B_FIN:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (is_error)
                    begin
                        error_seen_next = 1'b1;
                    end
                    if (item_reg.last_entry)
                    begin
                        error_seen_next  = 1'b0;
                        next_offset_next = '0;
                    end
                end
            default:
                status_next = status_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            issued_reg      <= 1'b0;
            error_seen_reg  <= 1'b0;
            next_offset_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            issued_reg      <= issued_next;
            error_seen_reg  <= error_seen_next;
            next_offset_reg <= next_offset_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        status_reg     <= status_next;
        align_step_reg <= align_step_next;
        res_blk_reg    <= res_blk_next;
        s_blk_reg      <= s_blk_next;
        z_blk_reg      <= z_blk_next;
        avail_reg      <= avail_next;
        end_reg        <= end_next;
        pad_reg        <= pad_next;
        if ((state_reg == B_FIN) && out_free)
        begin
            entry_number_reg <= item_reg.entry_idx + IDXW'(1);
            start_block_reg  <= (status_reg == ST_OK) ? s_blk_reg : '0;
            size_block_reg   <= (status_reg == ST_OK) ? z_blk_reg : '0;
            status_out_reg   <= status_reg;
            table_done_reg   <= item_reg.last_entry;
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_number = entry_number_reg;
    assign start_block  = start_block_reg;
    assign size_block   = size_block_reg;
    assign status       = status_out_reg;
    assign table_done   = table_done_reg;

endmodule

### rtl/partition_layout_calculator_top.sv
// Top level of the partition layout calculator: configuration registers and the pipeline parts.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     start_bytes, size_bytes, last_entry
// out       output     out_valid / out_ready   entry_number, start_block, size_block,
//                                              status, table_done
// cfg       input      cfg_write               cfg_index, cfg_data
//
// An entry that is ignored, aborted or meets a zero block size goes from idle straight to the final state.
// A laid-out entry runs five to seven passes through the shared bit-serial divider,
// plus six further steps (idle, check, limit, end sum, round and final state);
// the divider sets the rate.
// A two-entry queue lets new entries be taken while the sequencer works or while the
// output register waits for out_ready. Reset clears the table state and loads the
// register defaults; there is no clearing pass.
module partition_layout_calculator_top import plc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write,
    input  logic [1:0]      cfg_index,
    input  logic [FW-1:0]   cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [FW-1:0]   start_bytes,
    input  logic [FW-1:0]   size_bytes,
    input  logic            last_entry,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [IDXW-1:0] entry_number,
    output logic [FW-1:0]   start_block,
    output logic [FW-1:0]   size_block,
    output logic [2:0]      status,
    output logic            table_done
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     q_full;
    logic     q_push;
    item_t    q_in_item;
    logic     q_pop;
    item_t    q_head_item;
    logic     q_empty;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ALIGN:    cfg_next.align_bytes    = cfg_data;
                REG_RESERVED: cfg_next.reserved_bytes = cfg_data;
                REG_BSIZE:    cfg_next.block_size     = cfg_data[BSW-1:0];
                REG_TOTAL:    cfg_next.total_blocks   = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.align_bytes    <= '0;
            cfg_reg.reserved_bytes <= '0;
            cfg_reg.block_size     <= BSW'(512);
            cfg_reg.total_blocks   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    plc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_bytes (start_bytes),
        .size_bytes  (size_bytes),
        .last_entry  (last_entry),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_in_item)
    );

    plc_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .head_item (q_head_item),
        .empty     (q_empty)
    );

    plc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    plc_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_item       (q_head_item),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .entry_number (entry_number),
        .start_block  (start_block),
        .size_block   (size_block),
        .status       (status),
        .table_done   (table_done)
    );

endmodule
